>>> hdl/bfs_pkg.sv
// Shared types and constants for the banded forward substitution block.
package bfs_pkg;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_RHS     = 2'd1,
		OP_RESTART = 2'd2
	} op_t;

	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_BAND = 1'b1;

	localparam logic [10:0] ROWS_RESET = 11'd1024;

	localparam logic [31:0] SOL_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] SOL_MIN = 32'h8000_0000;
	localparam logic [63:0] ACC_LIMIT = 64'h0040_0000_0000_0000;

	typedef struct packed {
		logic start;
		logic load;
		logic restart;
		logic diag_rd;
		logic mac;
		logic absval;
		logic prep;
		logic check;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic mac_last;
		logic div_last;
	} sts_t;

endpackage

>>> hdl/bfs_ram.sv
// Generic simple dual-port RAM with registered read.
module bfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/bfs_ctrl.sv
// Sequencer for load, restart and solve transactions.
module bfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  bfs_pkg::op_t  in_op,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  bfs_pkg::sts_t sts,
	output bfs_pkg::cmd_t cmd
);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_DIAG  = 10'b00_0000_0010,
		ST_MAC   = 10'b00_0000_0100,
		ST_DR1   = 10'b00_0000_1000,
		ST_DR2   = 10'b00_0001_0000,
		ST_ABS   = 10'b00_0010_0000,
		ST_PREP  = 10'b00_0100_0000,
		ST_CHECK = 10'b00_1000_0000,
		ST_DIV   = 10'b01_0000_0000,
		ST_FIN   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_full_q;
	logic   accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_full_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_op)
						bfs_pkg::OP_LOAD:    cmd.load = 1'b1;
						bfs_pkg::OP_RESTART: cmd.restart = 1'b1;
						bfs_pkg::OP_RHS: begin
							cmd.start = 1'b1;
							state_d   = ST_DIAG;
						end
						default: ;
					endcase
				end
			end
			ST_DIAG: begin
				cmd.diag_rd = 1'b1;
				state_d     = ST_MAC;
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
				if (sts.mac_last) begin
					state_d = ST_DR1;
				end
			end
			ST_DR1: state_d = ST_DR2;
			ST_DR2: state_d = ST_ABS;
			ST_ABS: begin
				cmd.absval = 1'b1;
				state_d    = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold until the output register is free
				if (!out_full_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			out_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_full_q <= 1'b1;
			end else if (out_ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/bfs_dp.sv
// Datapath: coefficient store, solution ring, band MAC, divider, output register.
module bfs_dp #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_BAND = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_index,
	input  logic [10:0]         cfg_data,
	input  logic [9:0]          in_row,
	input  logic [3:0]          in_offset,
	input  logic signed [31:0]  in_value,
	input  bfs_pkg::cmd_t       cmd,
	output bfs_pkg::sts_t       sts,
	output logic [31:0]         solution,
	output logic [9:0]          solution_row,
	output logic                zero_pivot,
	output logic                last_row
);

	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int BW    = $clog2(MAX_BAND + 1);
	localparam int AW    = ROW_W + BW;
	localparam int DEPTH = MAX_ROWS * (2 ** BW);

	// configuration
	logic [10:0] rows_q;
	logic [3:0]  band_q;

	// per-row control
	logic [10:0]   cnt_q;
	logic [10:0]   row_q;
	logic          last_q;
	logic [BW-1:0] lim_q;
	logic [BW-1:0] step_q;

	// band MAC pipeline
	logic signed [31:0] ring_q [MAX_BAND];
	logic signed [31:0] tap_s1;
	logic               en_s1;
	logic               diag_s1;
	logic signed [63:0] prod_s2;
	logic               en_s2;
	logic signed [63:0] acc_q;
	logic signed [31:0] diag_q;

	// divider
	logic        acc_neg_q;
	logic        quot_neg_q;
	logic        piv_q;
	logic [54:0] ur_q;
	logic [31:0] ud_q;
	logic [62:0] num_q;
	logic        ovf_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  kbit_q;

	// output register
	logic [31:0] sol_q;
	logic [9:0]  orow_q;
	logic        opiv_q;
	logic        olast_q;

	logic [10:0]   n_eff;
	logic [BW-1:0] b_eff;
	logic [10:0]   i_cur;
	logic [BW-1:0] d_cur;
	logic [15:0]   ld_row16;
	logic [6:0]    ld_off7;
	logic [15:0]   row16;
	logic          mem_we;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;
	logic [63:0]   mag;
	logic [31:0]   ud_nxt;
	logic [31:0]   num_lo;
	logic [32:0]   trial;
	logic          ge;
	logic [31:0]   sol_nxt;

	always_comb begin
		if (rows_q == 11'd0) begin
			n_eff = 11'd1;
		end else if (32'(rows_q) > MAX_ROWS) begin
			n_eff = 11'(MAX_ROWS);
		end else begin
			n_eff = rows_q;
		end
		b_eff = (32'(band_q) > MAX_BAND) ? BW'(MAX_BAND) : BW'(band_q);
		i_cur = (cnt_q >= n_eff) ? 11'd0 : cnt_q;
	end

	assign d_cur    = step_q + BW'(1);
	assign ld_row16 = {6'b0, in_row};
	assign ld_off7  = {3'b0, in_offset};
	assign row16    = {5'b0, row_q};
	assign mem_we   = cmd.load && (32'(in_row) < MAX_ROWS) && (32'(in_offset) <= MAX_BAND);
	assign waddr    = {ld_row16[ROW_W-1:0], ld_off7[BW-1:0]};
	assign raddr    = {row16[ROW_W-1:0], cmd.diag_rd ? BW'(0) : d_cur};

	bfs_ram #(
		.WIDTH(32),
		.DEPTH(DEPTH)
	) u_coef (
		.clk  (clk),
		.we   (mem_we),
		.waddr(waddr),
		.wdata(in_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign sts.mac_last = (step_q == BW'(MAX_BAND - 1));
	assign sts.div_last = (kbit_q == 5'd0);

	assign mag    = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
	assign ud_nxt = diag_q[31] ? 32'(-diag_q) : 32'(diag_q);
	assign num_lo = num_q[31:0];
	assign trial  = {rem_q, num_lo[kbit_q]};
	assign ge     = (trial >= {1'b0, ud_q});

	always_comb begin
		if (piv_q) begin
			sol_nxt = acc_neg_q ? bfs_pkg::SOL_MIN : bfs_pkg::SOL_MAX;
		end else if (ovf_q) begin
			sol_nxt = quot_neg_q ? bfs_pkg::SOL_MIN : bfs_pkg::SOL_MAX;
		end else if (quot_neg_q) begin
			sol_nxt = (quo_q > bfs_pkg::SOL_MIN) ? bfs_pkg::SOL_MIN : 32'(-quo_q);
		end else begin
			sol_nxt = (quo_q > bfs_pkg::SOL_MAX) ? bfs_pkg::SOL_MAX : quo_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= bfs_pkg::ROWS_RESET;
			band_q  <= 4'd0;
			cnt_q   <= 11'd0;
			step_q  <= '0;
			kbit_q  <= 5'd0;
			en_s1   <= 1'b0;
			en_s2   <= 1'b0;
			diag_s1 <= 1'b0;
			for (int k = 0; k < MAX_BAND; k++) begin
				ring_q[k] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					bfs_pkg::CFG_ROWS: rows_q <= cfg_data;
					bfs_pkg::CFG_BAND: band_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (cmd.restart) begin
				cnt_q <= 11'd0;
			end else if (cmd.finish) begin
				cnt_q <= last_q ? 11'd0 : row_q + 11'd1;
			end
			if (cmd.start) begin
				step_q <= '0;
			end else if (cmd.mac && !sts.mac_last) begin
				step_q <= d_cur;
			end
			if (cmd.check) begin
				kbit_q <= 5'd31;
			end else if (cmd.div_step) begin
				kbit_q <= kbit_q - 5'd1;
			end
			en_s1   <= cmd.mac && (d_cur <= lim_q);
			en_s2   <= en_s1;
			diag_s1 <= cmd.diag_rd;
			// rotate a full turn during the MAC sweep, then shift in the new element
			if (cmd.mac) begin
				for (int k = 0; k < MAX_BAND - 1; k++) begin
					ring_q[k] <= ring_q[k+1];
				end
				ring_q[MAX_BAND-1] <= ring_q[0];
			end else if (cmd.finish) begin
				ring_q[0] <= sol_nxt;
				for (int k = 1; k < MAX_BAND; k++) begin
					ring_q[k] <= ring_q[k-1];
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			row_q  <= i_cur;
			last_q <= (i_cur + 11'd1 == n_eff);
			lim_q  <= (32'(i_cur) < 32'(b_eff)) ? BW'(i_cur) : b_eff;
			acc_q  <= {{24{in_value[31]}}, in_value, 8'b0};
		end else if (en_s2) begin
			acc_q <= acc_q - (prod_s2 >>> 8);
		end
		tap_s1  <= ring_q[0];
		prod_s2 <= $signed(rdata) * tap_s1;
		if (diag_s1) begin
			diag_q <= rdata;
		end
		if (cmd.absval) begin
			acc_neg_q  <= acc_q[63];
			quot_neg_q <= acc_q[63] ^ diag_q[31];
			piv_q      <= (diag_q == 32'sd0);
			ur_q       <= (mag > bfs_pkg::ACC_LIMIT) ? bfs_pkg::ACC_LIMIT[54:0] : mag[54:0];
			ud_q       <= ud_nxt;
		end
		if (cmd.prep) begin
			num_q <= {ur_q, 8'b0} + {32'b0, ud_q[31:1]};
		end
		if (cmd.check) begin
			ovf_q <= ({1'b0, num_q} >= {ud_q, 32'b0});
			rem_q <= {1'b0, num_q[62:32]};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? 32'(trial - {1'b0, ud_q}) : trial[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
		if (cmd.finish) begin
			sol_q   <= sol_nxt;
			orow_q  <= row_q[9:0];
			opiv_q  <= piv_q;
			olast_q <= last_q;
		end
	end

	assign solution     = sol_q;
	assign solution_row = orow_q;
	assign zero_pivot   = opiv_q;
	assign last_row     = olast_q;

endmodule

>>> hdl/banded_forward_substitution_top.sv
// Top level of the banded lower-triangular forward substitution solver.
//
// Input stream (s_*): each transaction carries an op in s_tuser. A load writes
// one Q16.16 coefficient at (row, offset below the diagonal); a restart clears
// the row counter; a right-hand-side element starts a solve of the next row.
// A load or restart is done in its accepting cycle and leaves s_tready high. A
// solve runs from its accepting cycle through one diagonal read, one sweep of
// the band through the coefficient RAM read port and the band multiplier, the
// drain states, the divider set-up states (absolute value, prep, check), the
// bit-serial divider and the write of the output register; m_tvalid rises
// once that register holds the result. s_tready is low during a solve.
// Output stream (m_*): one transaction per solved row, with the solution and
// its row in m_tdata, zero_pivot in m_tuser and m_tlast on the last row.
// A solve may start while the previous result still waits; if m_tready stays
// low, the new solve holds in its last cycle until the output register frees.
// Reset clears the row counter, the recent solutions and the configuration
// (rows_in_use 1024, band_width 0); coefficients are undefined until loaded.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data; the user must
// write it only while idle, and the block itself does not enforce this.
module banded_forward_substitution_top #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_BAND = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // row[9:0], offset[13:10], value[45:14], zero pad
	input  logic [1:0]  s_tuser,  // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // solution[31:0], solution_row[41:32], zero pad
	output logic [0:0]  m_tuser,  // zero_pivot[0]
	output logic        m_tlast
);

	bfs_pkg::cmd_t cmd;
	bfs_pkg::sts_t sts;
	logic [31:0]   solution;
	logic [9:0]    solution_row;
	logic          zero_pivot;
	logic          last_row;

	bfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (bfs_pkg::op_t'(s_tuser)),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bfs_dp #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_BAND(MAX_BAND)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_row      (s_tdata[9:0]),
		.in_offset   (s_tdata[13:10]),
		.in_value    (s_tdata[45:14]),
		.cmd         (cmd),
		.sts         (sts),
		.solution    (solution),
		.solution_row(solution_row),
		.zero_pivot  (zero_pivot),
		.last_row    (last_row)
	);

	assign m_tdata    = {6'b0, solution_row, solution};
	assign m_tuser[0] = zero_pivot;
	assign m_tlast    = last_row;

`ifndef SYNTHESIS
	// a new result never overwrites one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid || m_tready))
		else $error("result overwritten before transfer");

	// a solve blocks the input side on the following cycle
	a_solve_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == bfs_pkg::OP_RHS) |=> !s_tready)
		else $error("input accepted during a solve");

	// a zero pivot always comes with a saturated solution
	a_pivot_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |->
			(m_tdata[31:0] == bfs_pkg::SOL_MAX || m_tdata[31:0] == bfs_pkg::SOL_MIN))
		else $error("zero pivot without saturated solution");
`endif

endmodule

>>> tb/tb_banded_forward_substitution_top.sv
// Self-checking testbench for the banded forward substitution solver.
`timescale 1ns / 100ps

module tb_banded_forward_substitution_top;

	localparam int MAX_ROWS = 1024;
	localparam int MAX_BAND = 15;
	localparam int STRIDE = MAX_BAND + 1;
	localparam int SOLVE_CYCLES = MAX_BAND + 40;
	localparam int DRAIN_CYCLES = 2 * SOLVE_CYCLES;
	localparam int NUM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 80;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam longint ACC_CLAMP = 64'sh0040_0000_0000_0000;

	typedef struct packed {
		logic [31:0] solution;
		logic [9:0]  row;
		logic        pivot;
		logic        last;
	} solve_result_t;

	class solve_scoreboard;
		logic signed [31:0] coef [STRIDE * MAX_ROWS];
		bit                 written [STRIDE * MAX_ROWS];
		logic signed [31:0] recent [MAX_BAND];
		int unsigned        row_ctr;
		int unsigned        rows_reg;
		int unsigned        band_reg;
		solve_result_t      pending [$];
		int mismatches, n_loads, n_solves, n_restarts, n_ignored, n_pivots, n_ends;

		function new();
			foreach (recent[k]) recent[k] = '0;
			row_ctr = 0;
			rows_reg = bfs_pkg::ROWS_RESET;
			band_reg = 0;
		endfunction

		function void set_register(logic idx, logic [10:0] data);
			if (idx == bfs_pkg::CFG_ROWS) rows_reg = data;
			else band_reg = data[3:0];
		endfunction

		function int unsigned active_rows();
			if (rows_reg == 0) return 1;
			if (rows_reg > MAX_ROWS) return MAX_ROWS;
			return rows_reg;
		endfunction

		function int unsigned next_row();
			return (row_ctr >= active_rows()) ? 0 : row_ctr;
		endfunction

		function void note_input(logic [1:0] op, logic [9:0] row, logic [3:0] offset,
				logic signed [31:0] value);
			longint acc, prod, r, dv;
			longint unsigned ur, ud, q;
			logic signed [31:0] sol;
			int unsigned n, i;
			logic zp;
			solve_result_t res;
			case (op)
				bfs_pkg::OP_LOAD: begin
					coef[row * STRIDE + offset] = value;
					written[row * STRIDE + offset] = 1'b1;
					n_loads++;
				end
				bfs_pkg::OP_RESTART: begin
					row_ctr = 0;
					n_restarts++;
				end
				bfs_pkg::OP_RHS: begin
					n = active_rows();
					i = next_row();
					acc = longint'(value) * 256;
					for (int unsigned d = 1; d <= band_reg && d <= i; d++) begin
						prod = longint'(coef[i * STRIDE + d]) * longint'(recent[d - 1]);
						acc -= prod >>> 8;
					end
					dv = longint'(coef[i * STRIDE]);
					if (dv == 0) begin
						zp = 1'b1;
						sol = (acc >= 0) ? bfs_pkg::SOL_MAX : bfs_pkg::SOL_MIN;
					end else begin
						zp = 1'b0;
						r = acc;
						if (r > ACC_CLAMP) r = ACC_CLAMP;
						if (r < -ACC_CLAMP) r = -ACC_CLAMP;
						ur = (r < 0) ? -r : r;
						ud = (dv < 0) ? -dv : dv;
						// round the magnitude half away from zero
						q = ((ur << 8) + ud / 2) / ud;
						if ((r < 0) != (dv < 0))
							sol = (q > 64'h8000_0000) ? bfs_pkg::SOL_MIN : -q[31:0];
						else
							sol = (q > 64'h7FFF_FFFF) ? bfs_pkg::SOL_MAX : q[31:0];
					end
					for (int k = MAX_BAND - 1; k > 0; k--) recent[k] = recent[k - 1];
					recent[0] = sol;
					res = '{solution: sol, row: 10'(i), pivot: zp, last: (i + 1 == n)};
					pending = {pending, res};
					row_ctr = (i + 1 == n) ? 0 : i + 1;
					n_solves++;
					if (zp) n_pivots++;
					if (i + 1 == n) n_ends++;
				end
				default: n_ignored++;
			endcase
		endfunction

		function void check_result(logic [31:0] sol, logic [9:0] row, logic zp, logic last);
			solve_result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: sol %h row %0d pivot %b last %b",
						sol, row, zp, last);
				return;
			end
			want = pending.pop_front();
			if (want.solution !== sol || want.row !== row || want.pivot !== zp ||
					want.last !== last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected sol %h row %0d pivot %b last %b,",
						want.solution, want.row, want.pivot, want.last,
						" got sol %h row %0d pivot %b last %b",
						sol, row, zp, last);
			end
		endfunction

		function void finish_check();
			if (pending.size() != 0) begin
				$display("%0d expected results never arrived", pending.size());
				mismatches += pending.size();
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_index = 1'b0;
	logic [10:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        m_tlast;

	solve_scoreboard sb;
	int sender_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int hold_left = 0;
	int phase_rows [NUM_PHASES] = '{5, 16, 0, 2047, 3, 1024, 9, 1};
	int phase_band [NUM_PHASES] = '{2, 15, 1, 15, 0, 7, 15, 4};
	int phase_mode [NUM_PHASES] = '{0, 0, 0, 1, 1, 1, 2, 2};

	banded_forward_substitution_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_item(input logic [1:0] op, input logic [9:0] row,
			input logic [3:0] offset, input logic [31:0] value);
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, value, offset, row};
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_input(op, row, offset, value);
	endtask

	task automatic program_reg(input logic idx, input logic [10:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_register(idx, data);
		@(posedge clk);
	endtask

	// hold the input until every solve has come out, then let the block settle
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [31:0] coef_value(bit diag);
		int unsigned pick;
		logic [31:0] mag;
		pick = $urandom_range(0, 99);
		if (pick < 8) return diag ? 32'h0 : $urandom;
		if (pick < 18) return $urandom;
		if (diag) mag = $urandom_range(32'h4000, 32'h40000);
		else mag = $urandom_range(0, 32'h20000);
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	function automatic logic [31:0] rhs_value();
		int unsigned pick;
		logic [31:0] mag;
		pick = $urandom_range(0, 99);
		if (pick < 5) return $urandom_range(0, 1) ? bfs_pkg::SOL_MAX : bfs_pkg::SOL_MIN;
		if (pick < 20) return $urandom;
		mag = $urandom_range(0, 32'h80000);
		return $urandom_range(0, 1) ? -mag : mag;
	endfunction

	// load every band entry the next solve reads that was never written
	task automatic load_needed_coefs();
		int unsigned i, top;
		i = sb.next_row();
		top = (sb.band_reg < i) ? sb.band_reg : i;
		for (int unsigned d = 0; d <= top; d++)
			if (!sb.written[i * STRIDE + d])
				send_item(bfs_pkg::OP_LOAD, 10'(i), 4'(d), coef_value(d == 0));
	endtask

	task automatic random_item();
		int unsigned pick, hi;
		logic [9:0] row;
		logic [3:0] offset;
		pick = $urandom_range(0, 99);
		hi = sb.next_row() + 2;
		if (hi > sb.active_rows() - 1) hi = sb.active_rows() - 1;
		if (pick < 45) begin
			load_needed_coefs();
			send_item(bfs_pkg::OP_RHS, 10'($urandom), 4'($urandom), rhs_value());
		end else if (pick < 85) begin
			row = (pick < 72) ? 10'($urandom_range(0, hi)) : 10'($urandom);
			offset = 4'($urandom);
			send_item(bfs_pkg::OP_LOAD, row, offset, coef_value(offset == 0));
		end else if (pick < 92) begin
			send_item(bfs_pkg::OP_RESTART, 10'($urandom), 4'($urandom), $urandom);
		end else begin
			send_item(OP_UNUSED, 10'($urandom), 4'($urandom), $urandom);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			sb.check_result(m_tdata[31:0], m_tdata[41:32], m_tuser[0], m_tlast);
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 15;
		recv_idle_pct = 63;
		program_reg(bfs_pkg::CFG_ROWS, 11'd3);
		program_reg(bfs_pkg::CFG_BAND, 11'd15);
		send_item(bfs_pkg::OP_LOAD, 10'd0, 4'd0, 32'h0001_0000);
		send_item(bfs_pkg::OP_LOAD, 10'd1, 4'd0, 32'h8000_0000);
		send_item(bfs_pkg::OP_LOAD, 10'd1, 4'd1, 32'h7FFF_FFFF);
		send_item(bfs_pkg::OP_LOAD, 10'd2, 4'd0, 32'h0000_0000);
		send_item(bfs_pkg::OP_LOAD, 10'd2, 4'd1, 32'h8000_0000);
		send_item(bfs_pkg::OP_LOAD, 10'd2, 4'd2, 32'h0000_8000);
		send_item(bfs_pkg::OP_LOAD, 10'd1023, 4'd15, 32'hFFFF_FFFF);
		send_item(OP_UNUSED, 10'h3FF, 4'hF, 32'hFFFF_FFFF);
		send_item(bfs_pkg::OP_RHS, 10'd0, 4'd0, 32'h7FFF_FFFF);
		send_item(bfs_pkg::OP_RHS, 10'd0, 4'd0, 32'h8000_0000);
		// zero diagonal on the last row, then wrap to row zero
		send_item(bfs_pkg::OP_RHS, 10'd0, 4'd0, 32'h0000_0000);
		send_item(bfs_pkg::OP_RHS, 10'd0, 4'd0, 32'h1234_5678);
		send_item(bfs_pkg::OP_RESTART, 10'h3FF, 4'hF, 32'hFFFF_FFFF);
		send_item(bfs_pkg::OP_RHS, 10'h3FF, 4'hF, 32'hFFFF_FFFF);
		send_item(bfs_pkg::OP_RHS, 10'd0, 4'd0, 32'h0001_0000);
		send_item(bfs_pkg::OP_RESTART, 10'd0, 4'd0, 32'h0);
		// tiny negative divisor saturates
		send_item(bfs_pkg::OP_LOAD, 10'd0, 4'd0, 32'hFFFF_FFFF);
		send_item(bfs_pkg::OP_RHS, 10'd0, 4'd0, 32'h0100_0000);
		send_item(bfs_pkg::OP_RHS, 10'd0, 4'd0, 32'hFF00_0000);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			case (phase_mode[p])
				0: begin sender_idle_pct = 15; recv_idle_pct = 63; end
				1: begin sender_idle_pct = 63; recv_idle_pct = 15; end
				default: begin sender_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			program_reg(bfs_pkg::CFG_ROWS, 11'(phase_rows[p]));
			program_reg(bfs_pkg::CFG_BAND, 11'(phase_band[p]));
			// stall the output long enough to back the block up into its input
			if (p == 1) hold_req = 400;
			repeat (ITEMS_PER_PHASE) random_item();
		end

		wait_drained();
		sb.finish_check();
		$display("covered %0d coefficient loads and %0d solved rows",
			sb.n_loads, sb.n_solves,
			" (%0d zero pivots, %0d system ends)", sb.n_pivots, sb.n_ends);
		$display("with %0d restarts, %0d unused-op items, %0d register settings",
			sb.n_restarts, sb.n_ignored, 2 * NUM_PHASES + 2,
			" and a long output stall");
		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
hdl/bfs_pkg.sv
hdl/bfs_ram.sv
hdl/bfs_ctrl.sv
hdl/bfs_dp.sv
hdl/banded_forward_substitution_top.sv
tb/tb_banded_forward_substitution_top.sv
